### design/iem_pkg.sv
// ---------------------------------------------------------------------------
// iem_pkg: shared types and constants for the serial EEPROM bus master
// Command codes, bus phases, and the beat structures that travel between
// the front end, the bus engine and the result queue.
// ---------------------------------------------------------------------------
package iem_pkg;

  // Width of the memory address on the bus; above 8 a zero high byte is sent
  localparam int AddrWidth = 8;

  // Input mode field codes
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Classified command carried by one input beat
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  // Bus sequencer phases
  typedef enum logic [4:0] {
    PH_IDLE  = 5'd0,
    PH_ST1   = 5'd1,
    PH_CW    = 5'd2,
    PH_CWA   = 5'd3,
    PH_SPOLL = 5'd4,
    PH_AH    = 5'd5,
    PH_AHA   = 5'd6,
    PH_AL    = 5'd7,
    PH_ALA   = 5'd8,
    PH_WD    = 5'd9,
    PH_WDA   = 5'd10,
    PH_SEND  = 5'd11,
    PH_ST2   = 5'd12,
    PH_CR    = 5'd13,
    PH_CRA   = 5'd14,
    PH_RD    = 5'd15,
    PH_RDA   = 5'd16
  } phase_t;

  // One classified tick from the front end
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] mem_address;
    logic [7:0] write_data;
    logic [7:0] read_length;  // never zero
    logic       sda_in;
  } item_t;

  // One result beat
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       last_byte;
    logic       busy_res;
  } result_t;

endpackage

### design/iem_fifo.sv
// ---------------------------------------------------------------------------
// iem_fifo: two-entry beat queue
// Registered two-deep queue; full and empty come straight from the count.
// ---------------------------------------------------------------------------
module iem_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rdata   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### design/iem_front.sv
// ---------------------------------------------------------------------------
// iem_front: input acceptance and command classification
// Decodes the mode field, fixes a zero read length to one, and queues the
// classified beat for the bus engine.
// ---------------------------------------------------------------------------
module iem_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [1:0]    mode,
  input  logic [7:0]    mem_address,
  input  logic [7:0]    write_data,
  input  logic [7:0]    read_length,
  input  logic          sda_in,
  output iem_pkg::item_t item,
  output logic          item_valid,
  input  logic          item_pop
);
  import iem_pkg::*;

  item_t      item_in;
  logic       item_empty;
  logic [$bits(item_t)-1:0] item_bits;

  // classify the incoming beat; unused mode acts as a plain tick
  always_comb begin
    item_in.mem_address = mem_address;
    item_in.write_data  = write_data;
    item_in.read_length = (read_length == 8'd0) ? 8'd1 : read_length;
    item_in.sda_in      = sda_in;
    unique case (mode)
      MODE_WRITE: item_in.cmd = CMD_WRITE;
      MODE_READ:  item_in.cmd = CMD_READ;
      default:    item_in.cmd = CMD_TICK;
    endcase
  end

  iem_fifo #(.WIDTH($bits(item_t))) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (item_in),
    .full  (full),
    .pop   (item_pop),
    .rdata (item_bits),
    .empty (item_empty)
  );

  assign item       = item_t'(item_bits);
  assign item_valid = !item_empty;

endmodule

### design/iem_engine.sv
// ---------------------------------------------------------------------------
// iem_engine: quarter-bit bus sequencer
// Steps the bus state once per classified tick and produces one result beat
// per tick: line levels, received bytes and the busy flag.
// ---------------------------------------------------------------------------
module iem_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic [6:0]      device_address,
  input  iem_pkg::item_t  item,
  input  logic            item_valid,
  output logic            item_pop,
  output iem_pkg::result_t res,
  output logic            res_push,
  input  logic            res_full
);
  import iem_pkg::*;

  phase_t     phase, phase_next;
  logic [1:0] quarter_step, quarter_step_next;
  logic [2:0] bit_index, bit_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] saved_address, saved_address_next;
  logic [7:0] saved_data, saved_data_next;
  logic       is_read, is_read_next;
  logic       clock_out, clock_out_next;
  logic       data_out, data_out_next;
  logic       step;
  logic [7:0] ctrl;
  logic       last_rd;

  assign step     = item_valid && !res_full;
  assign item_pop = step;
  assign res_push = step;
  assign ctrl     = {device_address, 1'b0};
  assign last_rd  = (bytes_left <= 8'd1);

  // state register, advanced once per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      quarter_step  <= 2'd0;
      bit_index     <= 3'd7;
      shift_byte    <= 8'd0;
      bytes_left    <= 8'd0;
      saved_address <= 8'd0;
      saved_data    <= 8'd0;
      is_read       <= 1'b0;
      clock_out     <= 1'b1;
      data_out      <= 1'b1;
    end else if (step) begin
      phase         <= phase_next;
      quarter_step  <= quarter_step_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      bytes_left    <= bytes_left_next;
      saved_address <= saved_address_next;
      saved_data    <= saved_data_next;
      is_read       <= is_read_next;
      clock_out     <= clock_out_next;
      data_out      <= data_out_next;
    end
  end

  // next state and result beat
  always_comb begin
    phase_next         = phase;
    quarter_step_next  = quarter_step;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    bytes_left_next    = bytes_left;
    saved_address_next = saved_address;
    saved_data_next    = saved_data;
    is_read_next       = is_read;
    clock_out_next     = clock_out;
    data_out_next      = data_out;
    res.read_valid     = 1'b0;
    res.read_byte      = 8'd0;
    res.last_byte      = 1'b0;

    if (phase == PH_IDLE) begin
      // latch a command; the start condition begins on the next tick
      if (item.cmd == CMD_WRITE || item.cmd == CMD_READ) begin
        saved_address_next = item.mem_address;
        saved_data_next    = item.write_data;
        bytes_left_next    = item.read_length;
        is_read_next       = (item.cmd == CMD_READ);
        phase_next         = PH_ST1;
        quarter_step_next  = 2'd0;
      end
    end else begin
      quarter_step_next = quarter_step + 2'd1;
      unique case (phase)
        // start / repeated start
        PH_ST1, PH_ST2: begin
          case (quarter_step)
            2'd0: data_out_next  = 1'b1;
            2'd1: clock_out_next = 1'b1;
            2'd2: data_out_next  = 1'b0;
            default: begin
              clock_out_next = 1'b0;
              bit_index_next = 3'd7;
              if (phase == PH_ST1) begin
                phase_next      = PH_CW;
                shift_byte_next = ctrl;
              end else begin
                phase_next      = PH_CR;
                shift_byte_next = ctrl | 8'h01;
              end
            end
          endcase
        end
        // shift a byte out, MSB first
        PH_CW, PH_AH, PH_AL, PH_WD, PH_CR: begin
          case (quarter_step)
            2'd0: data_out_next  = shift_byte[bit_index];
            2'd1: clock_out_next = 1'b1;
            2'd2: ;
            default: begin
              clock_out_next = 1'b0;
              if (bit_index == 3'd0) begin
                phase_next     = phase_t'(phase + 5'd1);
                bit_index_next = 3'd7;
              end else begin
                bit_index_next = bit_index - 3'd1;
              end
            end
          endcase
        end
        // acknowledge slot from the device
        PH_CWA, PH_AHA, PH_ALA, PH_WDA, PH_CRA: begin
          case (quarter_step)
            2'd0: data_out_next  = 1'b1;
            2'd1: clock_out_next = 1'b1;
            2'd2: shift_byte_next = {7'd0, item.sda_in};
            default: begin
              clock_out_next = 1'b0;
              case (phase)
                PH_CWA: begin
                  if (shift_byte[0]) begin
                    phase_next = PH_SPOLL;
                  end else if (AddrWidth > 8) begin
                    phase_next      = PH_AH;
                    shift_byte_next = 8'd0;
                    bit_index_next  = 3'd7;
                  end else begin
                    phase_next      = PH_AL;
                    shift_byte_next = saved_address;
                    bit_index_next  = 3'd7;
                  end
                end
                PH_AHA: begin
                  phase_next      = PH_AL;
                  shift_byte_next = saved_address;
                  bit_index_next  = 3'd7;
                end
                PH_ALA: begin
                  if (is_read) begin
                    phase_next = PH_ST2;
                  end else begin
                    phase_next      = PH_WD;
                    shift_byte_next = saved_data;
                    bit_index_next  = 3'd7;
                  end
                end
                PH_WDA: phase_next = PH_SEND;
                default: begin
                  phase_next      = PH_RD;
                  shift_byte_next = 8'd0;
                  bit_index_next  = 3'd7;
                end
              endcase
            end
          endcase
        end
        // shift a byte in
        PH_RD: begin
          case (quarter_step)
            2'd0: data_out_next  = 1'b1;
            2'd1: clock_out_next = 1'b1;
            2'd2: shift_byte_next = {shift_byte[6:0], item.sda_in};
            default: begin
              clock_out_next = 1'b0;
              if (bit_index == 3'd0) begin
                res.read_valid = 1'b1;
                res.read_byte  = shift_byte;
                res.last_byte  = last_rd;
                phase_next     = PH_RDA;
                bit_index_next = 3'd7;
              end else begin
                bit_index_next = bit_index - 3'd1;
              end
            end
          endcase
        end
        // master ack, nack on the last byte
        PH_RDA: begin
          case (quarter_step)
            2'd0: data_out_next  = last_rd;
            2'd1: clock_out_next = 1'b1;
            2'd2: ;
            default: begin
              clock_out_next = 1'b0;
              if (last_rd) begin
                bytes_left_next = 8'd0;
                phase_next      = PH_SEND;
              end else begin
                bytes_left_next = bytes_left - 8'd1;
                phase_next      = PH_RD;
                shift_byte_next = 8'd0;
                bit_index_next  = 3'd7;
              end
            end
          endcase
        end
        // stop condition, then retry or finish
        PH_SPOLL, PH_SEND: begin
          case (quarter_step)
            2'd0: begin
              clock_out_next = 1'b0;
              data_out_next  = 1'b0;
            end
            2'd1: clock_out_next = 1'b1;
            2'd2: data_out_next  = 1'b1;
            default: phase_next = (phase == PH_SPOLL) ? PH_ST1 : PH_IDLE;
          endcase
        end
        // unknown phase: release the bus
        default: begin
          phase_next     = PH_IDLE;
          clock_out_next = 1'b1;
          data_out_next  = 1'b1;
        end
      endcase
    end

    res.scl_level = clock_out_next;
    res.sda_level = data_out_next;
    res.busy_res  = (phase_next != PH_IDLE);
  end

endmodule

### design/i2c_eeprom_master.sv
// ---------------------------------------------------------------------------
// i2c_eeprom_master: serial EEPROM bus master, one quarter bit per beat
// Front end classifies input beats into a short queue; the bus engine steps
// once per beat and writes one result beat into the result queue.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (push/full): every beat is one quarter-bit bus tick with
//   the sampled data line. A tick with mode write or read while idle latches
//   a command; commands while busy are ignored.
//   Result channel (empty/pop): exactly one result beat per input beat, in
//   order: clock and data line levels, a received byte with its last flag,
//   and the busy flag.
//   Config: cfg_write loads the 7-bit device address; write it only while
//   no command is running.
//   Path: an accepted input beat is registered in the input queue; the engine
//   steps on it and its result is registered in the result queue, where it is
//   visible with empty low. Throughput: one beat per cycle while results are
//   popped, the engine stepping between two two-entry queues.
//   When pop is held low the result queue fills, the engine stops stepping,
//   and full rises once the input queue is also full; no beat is dropped.
//   Reset (rst, synchronous): queues empty, engine idle with both lines
//   released, device address 81.
// ---------------------------------------------------------------------------
module i2c_eeprom_master (
  input  logic       clk,
  input  logic       rst,
  // input beats
  input  logic       push,
  output logic       full,
  input  logic [1:0] mode,
  input  logic [7:0] mem_address,
  input  logic [7:0] write_data,
  input  logic [7:0] read_length,
  input  logic       sda_in,
  // configuration
  input  logic       cfg_write,
  input  logic [6:0] cfg_data,
  // result beats
  output logic       empty,
  input  logic       pop,
  output logic       scl_level,
  output logic       sda_level,
  output logic       read_valid,
  output logic [7:0] read_byte,
  output logic       last_byte,
  output logic       busy_res
);
  import iem_pkg::*;

  logic [6:0] device_address;
  item_t      item;
  logic       item_valid;
  logic       item_pop;
  result_t    res;
  logic       res_push;
  logic       res_full;
  logic [$bits(result_t)-1:0] res_bits;
  result_t    res_out;

  // device address register
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 7'd81;
    end else if (cfg_write) begin
      device_address <= cfg_data;
    end
  end

  iem_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .mode        (mode),
    .mem_address (mem_address),
    .write_data  (write_data),
    .read_length (read_length),
    .sda_in      (sda_in),
    .item        (item),
    .item_valid  (item_valid),
    .item_pop    (item_pop)
  );

  iem_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .device_address (device_address),
    .item           (item),
    .item_valid     (item_valid),
    .item_pop       (item_pop),
    .res            (res),
    .res_push       (res_push),
    .res_full       (res_full)
  );

  iem_fifo #(.WIDTH($bits(result_t))) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_bits),
    .empty (empty)
  );

  assign res_out    = result_t'(res_bits);
  assign scl_level  = res_out.scl_level;
  assign sda_level  = res_out.sda_level;
  assign read_valid = res_out.read_valid;
  assign read_byte  = res_out.read_byte;
  assign last_byte  = res_out.last_byte;
  assign busy_res   = res_out.busy_res;

  // engine only steps on a queued beat with room for its result
  a_step_has_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (item_valid && !res_full))
    else $error("engine stepped without input beat or result room");

  // a received byte always arrives mid-command
  a_byte_busy: assert property (@(posedge clk) disable iff (rst)
    (!empty && read_valid) |-> busy_res)
    else $error("received byte reported while idle");

  // last flag only travels with a byte
  a_last_has_byte: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_byte) |-> read_valid)
    else $error("last flag without a received byte");

  // a beat that waits for pop stays unchanged
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(res_bits)))
    else $error("waiting result beat changed");

endmodule
